[design/lbps_pkg.sv]
`default_nettype none

package lbps_pkg;

   localparam int NUM_PATTERNS      = 4;
   localparam int STEPS_PER_PATTERN = 4;

   localparam int PAT_W         = 2;
   localparam int STEP_W        = 2;
   localparam int MS_W          = 16;
   localparam int REP_W         = 8;
   localparam int CNT_W         = 3;
   localparam int USED_W        = 3;
   localparam int MASK_W        = NUM_PATTERNS;
   localparam int STEP_COUNTS_W = CNT_W * NUM_PATTERNS;
   localparam int PHASE_W       = 3;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 16;

   localparam int ROWS  = NUM_PATTERNS * STEPS_PER_PATTERN / 2;
   localparam int ROW_W = PAT_W + STEP_W - 1;

   localparam logic [MS_W-1:0] IDLE_POLL_MS = 16'd50;

   typedef enum logic [1:0] {
      ACT_TICK       = 2'd0,
      ACT_SET_ACTIVE = 2'd1,
      ACT_CLEAR_ALL  = 2'd2,
      ACT_WRITE_STEP = 2'd3
   } action_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_IDLE  = 3'd0,
      PH_ON    = 3'd1,
      PH_OFF   = 3'd2,
      PH_INTER = 3'd3,
      PH_FRAME = 3'd4
   } phase_code_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ON    = 5'b00010,
      ST_OFF   = 5'b00100,
      ST_INTER = 5'b01000,
      ST_FRAME = 5'b10000
   } state_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_INTER_GAP   = 3'd0,
      REG_FRAME_GAP   = 3'd1,
      REG_PATTERNS    = 3'd2,
      REG_CONT_MASK   = 3'd3,
      REG_STEP_COUNTS = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [REP_W-1:0] repeat_count;
      logic [MS_W-1:0]  off_ms;
      logic [MS_W-1:0]  on_ms;
   } step_entry_type;

   typedef struct packed {
      action_type       action;
      logic [PAT_W-1:0] pattern_index;
      logic [STEP_W-1:0] step_index;
      logic             active;
      step_entry_type   entry;
   } item_type;

   typedef struct packed {
      logic [MS_W-1:0]          inter_gap_ms;
      logic [MS_W-1:0]          frame_gap_ms;
      logic [USED_W-1:0]        patterns_in_use;
      logic [MASK_W-1:0]        continuous_mask;
      logic [STEP_COUNTS_W-1:0] step_counts;
   } cfg_type;

   typedef struct packed {
      logic              led_on;
      phase_code_type    phase;
      logic [PAT_W-1:0]  current_pattern;
      logic [STEP_W-1:0] current_step;
   } status_type;

   typedef struct packed {
      logic              en;
      logic [PAT_W-1:0]  pattern;
      logic [STEP_W-1:0] step;
      step_entry_type    entry;
   } store_wr_type;

   typedef struct packed {
      logic [PAT_W-1:0]  pattern;
      logic [STEP_W-1:0] step;
      logic [PAT_W-1:0]  first_pattern;
   } store_addr_type;

   typedef struct packed {
      step_entry_type  cur;
      logic [MS_W-1:0] next_on;
      logic [MS_W-1:0] first_on;
   } store_rd_type;

endpackage

`default_nettype wire

[design/lbps_step_store.sv]
`default_nettype none

module lbps_step_store (
   input  wire                           clock,
   input  wire lbps_pkg::store_wr_type   wr,
   input  wire lbps_pkg::store_addr_type addr,
   output lbps_pkg::store_rd_type        rd
);
   import lbps_pkg::*;

   // even and odd steps live in separate banks so a step and its successor
   // come out together; step 0 of each pattern is mirrored for pattern starts
   step_entry_type  even_ff [ROWS];
   step_entry_type  odd_ff  [ROWS];
   logic [MS_W-1:0] first_on_ff [NUM_PATTERNS];

   logic [ROW_W-1:0]  wr_row;
   logic [STEP_W-1:0] step_plus;
   logic [ROW_W-1:0]  even_row;
   logic [ROW_W-1:0]  odd_row;

   assign wr_row    = {wr.pattern, wr.step[STEP_W-1:1]};
   assign step_plus = addr.step + STEP_W'(1);
   assign even_row  = {addr.pattern,
                       addr.step[0] ? step_plus[STEP_W-1:1] : addr.step[STEP_W-1:1]};
   assign odd_row   = {addr.pattern, addr.step[STEP_W-1:1]};

   always_ff @(posedge clock) begin
      if (wr.en) begin
         if (wr.step[0]) begin
            odd_ff[wr_row] <= wr.entry;
         end else begin
            even_ff[wr_row] <= wr.entry;
         end
         if (wr.step == '0) begin
            first_on_ff[wr.pattern] <= wr.entry.on_ms;
         end
      end
   end

   always_comb begin
      if (addr.step[0]) begin
         rd.cur     = odd_ff[odd_row];
         rd.next_on = even_ff[even_row].on_ms;
      end else begin
         rd.cur     = even_ff[even_row];
         rd.next_on = odd_ff[odd_row].on_ms;
      end
      rd.first_on = first_on_ff[addr.first_pattern];
   end

endmodule

`default_nettype wire

[design/lbps_player.sv]
`default_nettype none

module lbps_player (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        go,
   input  wire lbps_pkg::item_type    item,
   input  wire lbps_pkg::cfg_type     cfg,
   output lbps_pkg::status_type       status_in
);
   import lbps_pkg::*;

   logic [NUM_PATTERNS-1:0] active_ff, active_in;
   state_type               phase_ff, phase_in;
   logic [PAT_W-1:0]        pat_ff, pat_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [REP_W-1:0]        pulse_ff, pulse_in;
   logic [MS_W-1:0]         remain_ff, remain_in;
   logic                    led_ff, led_in;

   store_wr_type   st_wr;
   store_addr_type st_addr;
   store_rd_type   st_rd;

   logic [USED_W-1:0]       used;
   logic [CNT_W-1:0]        cnt_fld;
   logic [CNT_W-1:0]        cnt_arr [NUM_PATTERNS];
   logic [NUM_PATTERNS-1:0] defined;
   logic [NUM_PATTERNS-1:0] cont_act;
   logic [NUM_PATTERNS-1:0] def_act;
   logic                    c_found, f_found, nx_found;
   logic [PAT_W-1:0]        c_idx, f_idx, nx_idx;

   logic                    playing;
   logic                    restart;
   logic [REP_W-1:0]        pulse_nx;
   logic [STEP_W-1:0]       step_nx;
   logic [CNT_W-1:0]        cnt_cur;
   logic                    step_over;
   logic                    has_next;
   logic [MS_W-1:0]         rem_dec;

   state_type               a_phase;
   logic [PAT_W-1:0]        a_pat;
   logic [STEP_W-1:0]       a_step;
   logic [REP_W-1:0]        a_pulse;
   logic [MS_W-1:0]         a_rem;
   logic                    a_led;
   logic [MS_W-1:0]         start_rem;

   always_comb begin
      cnt_fld = '0;
      used = (cfg.patterns_in_use > USED_W'(NUM_PATTERNS)) ? USED_W'(NUM_PATTERNS)
                                                           : cfg.patterns_in_use;
      for (int p = 0; p < NUM_PATTERNS; p++) begin
         cnt_fld    = cfg.step_counts[CNT_W*p +: CNT_W];
         cnt_arr[p] = (cnt_fld > CNT_W'(STEPS_PER_PATTERN)) ? CNT_W'(STEPS_PER_PATTERN)
                                                            : cnt_fld;
         defined[p]  = USED_W'(p) < used;
         cont_act[p] = defined[p] && cfg.continuous_mask[p] && active_ff[p];
         def_act[p]  = defined[p] && !cfg.continuous_mask[p] && active_ff[p];
      end
   end

   always_comb begin
      c_found  = 1'b0;
      c_idx    = '0;
      f_found  = 1'b0;
      f_idx    = '0;
      nx_found = 1'b0;
      nx_idx   = '0;
      for (int p = NUM_PATTERNS - 1; p >= 0; p--) begin
         if (cont_act[p]) begin
            c_found = 1'b1;
            c_idx   = PAT_W'(p);
         end
         if (def_act[p]) begin
            f_found = 1'b1;
            f_idx   = PAT_W'(p);
         end
         if (def_act[p] && (PAT_W'(p) > pat_ff)) begin
            nx_found = 1'b1;
            nx_idx   = PAT_W'(p);
         end
      end
   end

   assign playing   = (phase_ff == ST_ON) || (phase_ff == ST_OFF);
   assign restart   = (playing && (!defined[pat_ff] || cfg.continuous_mask[pat_ff]))
                      || (phase_ff == ST_IDLE) || (phase_ff == ST_FRAME);
   assign pulse_nx  = pulse_ff + REP_W'(1);
   assign step_nx   = step_ff + STEP_W'(1);
   assign cnt_cur   = c_found ? cnt_arr[c_idx] : cnt_arr[pat_ff];
   assign step_over = {1'b0, step_ff} >= cnt_cur;
   assign has_next  = ({1'b0, step_ff} + CNT_W'(1)) < cnt_cur;
   assign rem_dec   = (remain_ff != '0) ? remain_ff - MS_W'(1) : remain_ff;

   assign st_addr.pattern       = pat_ff;
   assign st_addr.step          = step_ff;
   assign st_addr.first_pattern = c_found ? c_idx : (restart ? f_idx : nx_idx);
   assign start_rem = (cnt_arr[st_addr.first_pattern] != '0) ? st_rd.first_on : '0;

   assign st_wr.en      = go && (item.action == ACT_WRITE_STEP);
   assign st_wr.pattern = item.pattern_index;
   assign st_wr.step    = item.step_index;
   assign st_wr.entry   = item.entry;

   lbps_step_store u_store (
      .clock (clock),
      .wr    (st_wr),
      .addr  (st_addr),
      .rd    (st_rd)
   );

   always_comb begin
      a_phase = phase_ff;
      a_pat   = pat_ff;
      a_step  = step_ff;
      a_pulse = pulse_ff;
      a_rem   = remain_ff;
      a_led   = led_ff;
      if (c_found) begin
         if (cnt_cur == '0) begin
            a_pat   = c_idx;
            a_step  = '0;
            a_pulse = '0;
            a_phase = ST_OFF;
            a_led   = 1'b0;
            a_rem   = IDLE_POLL_MS;
         end else if (!playing || (pat_ff != c_idx) || step_over) begin
            a_pat   = c_idx;
            a_step  = '0;
            a_pulse = '0;
            a_phase = ST_ON;
            a_led   = 1'b1;
            a_rem   = start_rem;
         end else if (phase_ff == ST_ON) begin
            a_phase = ST_OFF;
            a_led   = 1'b0;
            a_rem   = st_rd.cur.off_ms;
         end else begin
            a_phase = ST_ON;
            a_led   = 1'b1;
            if (pulse_nx >= st_rd.cur.repeat_count) begin
               a_pulse = '0;
               if (has_next) begin
                  a_step = step_nx;
                  a_rem  = st_rd.next_on;
               end else begin
                  a_step = '0;
                  a_rem  = st_rd.first_on;
               end
            end else begin
               a_pulse = pulse_nx;
               a_rem   = st_rd.cur.on_ms;
            end
         end
      end else if (restart) begin
         if (f_found) begin
            a_pat   = f_idx;
            a_step  = '0;
            a_pulse = '0;
            a_phase = ST_ON;
            a_led   = 1'b1;
            a_rem   = start_rem;
         end else begin
            a_phase = ST_IDLE;
            a_led   = 1'b0;
            a_rem   = IDLE_POLL_MS;
         end
      end else if (phase_ff == ST_INTER) begin
         if (nx_found) begin
            a_pat   = nx_idx;
            a_step  = '0;
            a_pulse = '0;
            a_phase = ST_ON;
            a_led   = 1'b1;
            a_rem   = start_rem;
         end else begin
            a_phase = ST_FRAME;
            a_led   = 1'b0;
            a_rem   = cfg.frame_gap_ms;
         end
      end else if (!step_over && (phase_ff == ST_ON)) begin
         a_phase = ST_OFF;
         a_led   = 1'b0;
         a_rem   = st_rd.cur.off_ms;
      end else if (!step_over && (pulse_nx < st_rd.cur.repeat_count)) begin
         a_pulse = pulse_nx;
         a_phase = ST_ON;
         a_led   = 1'b1;
         a_rem   = st_rd.cur.on_ms;
      end else if (!step_over && has_next) begin
         a_pulse = '0;
         a_step  = step_nx;
         a_phase = ST_ON;
         a_led   = 1'b1;
         a_rem   = st_rd.next_on;
      end else begin
         if (!step_over) begin
            a_pulse = '0;
         end
         a_led = 1'b0;
         if (nx_found) begin
            a_phase = ST_INTER;
            a_rem   = cfg.inter_gap_ms;
         end else begin
            a_phase = ST_FRAME;
            a_rem   = cfg.frame_gap_ms;
         end
      end
   end

   always_comb begin
      active_in = active_ff;
      phase_in  = phase_ff;
      pat_in    = pat_ff;
      step_in   = step_ff;
      pulse_in  = pulse_ff;
      remain_in = remain_ff;
      led_in    = led_ff;
      if (go) begin
         case (item.action)
            ACT_TICK: begin
               remain_in = rem_dec;
               if (rem_dec == '0) begin
                  phase_in  = a_phase;
                  pat_in    = a_pat;
                  step_in   = a_step;
                  pulse_in  = a_pulse;
                  remain_in = a_rem;
                  led_in    = a_led;
               end
            end
            ACT_SET_ACTIVE: begin
               if (defined[item.pattern_index]) begin
                  active_in[item.pattern_index] = item.active;
               end
            end
            ACT_CLEAR_ALL: begin
               active_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      status_in.led_on          = led_in;
      status_in.current_pattern = pat_in;
      status_in.current_step    = step_in;
      case (phase_in)
         ST_IDLE:  status_in.phase = PH_IDLE;
         ST_ON:    status_in.phase = PH_ON;
         ST_OFF:   status_in.phase = PH_OFF;
         ST_INTER: status_in.phase = PH_INTER;
         ST_FRAME: status_in.phase = PH_FRAME;
         default:  status_in.phase = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         phase_ff  <= ST_IDLE;
         pat_ff    <= '0;
         step_ff   <= '0;
         pulse_ff  <= '0;
         remain_ff <= IDLE_POLL_MS;
         led_ff    <= 1'b0;
      end else begin
         active_ff <= active_in;
         phase_ff  <= phase_in;
         pat_ff    <= pat_in;
         step_ff   <= step_in;
         pulse_ff  <= pulse_in;
         remain_ff <= remain_in;
         led_ff    <= led_in;
      end
   end

endmodule

`default_nettype wire

[design/led_blink_pattern_sequencer.sv]
`default_nettype none

// channel   direction  handshake                  payload
// req_      in         req_valid / req_ready      action, pattern/step index, active,
//                                                 on_ms, off_ms, repeat_count
// rsp_      out        rsp_valid / rsp_ready      led_on, phase, current_pattern,
//                                                 current_step
// csr_      in         csr_wen                    csr_index, csr_wdata
//
// One request per cycle sustained while responses are taken; a response passes
// through the input register, then the result register, before it turns valid.
// The sequencer state updates in the cycle a request moves from the input
// register into the result register.
// A stalled response holds the input register; one more request is still taken.
// Synchronous reset clears the sequencer and config; step storage has no reset.

module led_blink_pattern_sequencer (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  [1:0]                          req_action,
   input  wire  [lbps_pkg::PAT_W-1:0]          req_pattern_index,
   input  wire  [lbps_pkg::STEP_W-1:0]         req_step_index,
   input  wire                                 req_active,
   input  wire  [lbps_pkg::MS_W-1:0]           req_on_ms,
   input  wire  [lbps_pkg::MS_W-1:0]           req_off_ms,
   input  wire  [lbps_pkg::REP_W-1:0]          req_repeat_count,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic                                rsp_led_on,
   output logic [lbps_pkg::PHASE_W-1:0]        rsp_phase,
   output logic [lbps_pkg::PAT_W-1:0]          rsp_current_pattern,
   output logic [lbps_pkg::STEP_W-1:0]         rsp_current_step,
   input  wire                                 csr_wen,
   input  wire  [lbps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [lbps_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import lbps_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff, in_item_in;
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff;
   status_type status_in;
   cfg_type    cfg_ff, cfg_in;
   logic       go;
   logic       req_accept;

   assign go         = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || go;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      in_item_in.action        = action_type'(req_action);
      in_item_in.pattern_index = req_pattern_index;
      in_item_in.step_index    = req_step_index;
      in_item_in.active        = req_active;
      in_item_in.entry.on_ms        = req_on_ms;
      in_item_in.entry.off_ms       = req_off_ms;
      in_item_in.entry.repeat_count = req_repeat_count;
   end

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (go) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            REG_INTER_GAP:   cfg_in.inter_gap_ms    = csr_wdata[MS_W-1:0];
            REG_FRAME_GAP:   cfg_in.frame_gap_ms    = csr_wdata[MS_W-1:0];
            REG_PATTERNS:    cfg_in.patterns_in_use = csr_wdata[USED_W-1:0];
            REG_CONT_MASK:   cfg_in.continuous_mask = csr_wdata[MASK_W-1:0];
            REG_STEP_COUNTS: cfg_in.step_counts     = csr_wdata[STEP_COUNTS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   lbps_player u_player (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .item      (in_item_ff),
      .cfg       (cfg_ff),
      .status_in (status_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= in_item_in;
      end
      if (go) begin
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_led_on          = rsp_status_ff.led_on;
   assign rsp_phase           = rsp_status_ff.phase;
   assign rsp_current_pattern = rsp_status_ff.current_pattern;
   assign rsp_current_step    = rsp_status_ff.current_step;

   a_go_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      go |=> rsp_valid_ff)
      else $error("processed request did not reach the response register");

   a_led_matches_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff.led_on == (rsp_status_ff.phase == PH_ON)))
      else $error("LED level disagrees with phase");

   a_pending_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !go) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("pending request lost or overwritten");

endmodule

`default_nettype wire
